FILE: rtl/mi4_pkg.sv
// Shared constants and types for the 4x4 fixed-point matrix inverse.
package mi4_pkg;

   localparam int DATA_WIDTH = 32;
   localparam int FRAC_BITS  = 16;

   localparam int NUM_ELEMS = 16;
   localparam int IDX_W     = 4;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_ELEMS - 1);

   // Two banks of sixteen elements in the matrix store.
   localparam int MAT_DEPTH = 2 * NUM_ELEMS;
   localparam int MAT_AW    = $clog2(MAT_DEPTH);

   // Exact widths of the intermediate values.
   localparam int MIN_W = 2 * DATA_WIDTH + 1;
   localparam int COF_W = 3 * DATA_WIDTH + 4;
   localparam int DET_W = 4 * DATA_WIDTH + 6;

   // The wide operand of a product is walked in limbs of this width.
   localparam int LIMB_W     = 16;
   localparam int NL_E       = (DATA_WIDTH + LIMB_W - 1) / LIMB_W;
   localparam int NL_M       = (MIN_W + LIMB_W - 1) / LIMB_W;
   localparam int NL_C       = (COF_W + LIMB_W - 1) / LIMB_W;
   localparam int OPB_W      = NL_C * LIMB_W;
   localparam int LIMB_CNT_W = $clog2(NL_C);
   localparam int PROD_W     = DATA_WIDTH + LIMB_W + 1;

   localparam logic [LIMB_CNT_W-1:0] TOP_E = LIMB_CNT_W'(NL_E - 1);
   localparam logic [LIMB_CNT_W-1:0] TOP_M = LIMB_CNT_W'(NL_M - 1);
   localparam logic [LIMB_CNT_W-1:0] TOP_C = LIMB_CNT_W'(NL_C - 1);

   // Divider working width: holds the scaled numerator and the shifted divisor.
   localparam int DIV_A = 3 * DATA_WIDTH + 2 * FRAC_BITS + 6;
   localparam int DIV_B = 5 * DATA_WIDTH + 8;
   localparam int DIV_W = (DIV_A > DIV_B) ? DIV_A : DIV_B;
   localparam int QCNT_W = $clog2(DATA_WIDTH);

   // A loaded matrix waiting for the back end.
   typedef struct packed {
      logic valid;
      logic bank;
   } job_type;

   // Back end handshake to the front end.
   typedef struct packed {
      logic pop;
      logic free_bank;
   } job_ctl_type;

endpackage

FILE: rtl/mi4_ram.sv
// Generic single write port, single read port RAM with registered read data.
module mi4_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/mi4_front.sv
// Front end: takes matrix elements, fills a store bank and queues full matrices.
module mi4_front import mi4_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   output logic                         full,
   input  logic signed [DATA_WIDTH-1:0] req_element,
   output logic                         mat_we,
   output logic [MAT_AW-1:0]            mat_waddr,
   output logic [DATA_WIDTH-1:0]        mat_wdata,
   output job_type                      job,
   input  job_ctl_type                  job_ctl
);

   logic [IDX_W-1:0] load_count_ff, load_count_in;
   logic             fill_bank_ff, fill_bank_in;
   logic [1:0]       busy_ff, busy_in;
   logic             q_bank_ff [2];
   logic             q_wr_ff, q_wr_in;
   logic             q_rd_ff, q_rd_in;
   logic [1:0]       q_count_ff, q_count_in;
   logic             accept;
   logic             loaded;

   // Both banks hold a matrix that the back end still needs.
   assign full   = (busy_ff == 2'd2);
   assign accept = push && !full;
   assign loaded = accept && (load_count_ff == LAST_IDX);

   assign mat_we    = accept;
   assign mat_waddr = {fill_bank_ff, load_count_ff};
   assign mat_wdata = req_element;

   assign job.valid = (q_count_ff != 2'd0);
   assign job.bank  = q_bank_ff[q_rd_ff];

   always_comb begin
      load_count_in = load_count_ff;
      fill_bank_in  = fill_bank_ff;
      busy_in       = busy_ff;
      q_wr_in       = q_wr_ff;
      q_rd_in       = q_rd_ff;
      q_count_in    = q_count_ff;
      if (accept) begin
         load_count_in = load_count_ff + 1'b1;
      end
      if (loaded) begin
         fill_bank_in = !fill_bank_ff;
         q_wr_in      = !q_wr_ff;
      end
      if (job_ctl.pop) begin
         q_rd_in = !q_rd_ff;
      end
      case ({loaded, job_ctl.pop})
         2'b10: q_count_in = q_count_ff + 2'd1;
         2'b01: q_count_in = q_count_ff - 2'd1;
         default: q_count_in = q_count_ff;
      endcase
      case ({loaded, job_ctl.free_bank})
         2'b10: busy_in = busy_ff + 2'd1;
         2'b01: busy_in = busy_ff - 2'd1;
         default: busy_in = busy_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_count_ff <= '0;
         fill_bank_ff  <= 1'b0;
         busy_ff       <= 2'd0;
         q_wr_ff       <= 1'b0;
         q_rd_ff       <= 1'b0;
         q_count_ff    <= 2'd0;
      end else begin
         load_count_ff <= load_count_in;
         fill_bank_ff  <= fill_bank_in;
         busy_ff       <= busy_in;
         q_wr_ff       <= q_wr_in;
         q_rd_ff       <= q_rd_in;
         q_count_ff    <= q_count_in;
      end
      if (loaded) begin
         q_bank_ff[q_wr_ff] <= fill_bank_ff;
      end
   end

endmodule

FILE: rtl/mi4_div.sv
// Restoring divider: rounded, saturated quotient of a cofactor by the determinant.
module mi4_div import mi4_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [COF_W-1:0]      cof,
   input  logic [DET_W-1:0]      det,
   output logic                  done,
   output logic [DATA_WIDTH-1:0] quot
);

   typedef enum logic [2:0] {
      D_IDLE,
      D_PREP,
      D_CHK,
      D_ITER,
      D_DONE
   } dstate_type;

   localparam logic [DATA_WIDTH-1:0] MAXV = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam logic [DATA_WIDTH-1:0] MINV = {1'b1, {(DATA_WIDTH-1){1'b0}}};

   dstate_type              state_ff, state_in;
   logic                    neg_ff, neg_in;
   logic                    ovf_ff, ovf_in;
   logic [COF_W-1:0]        n_ff, n_in;
   logic [DET_W-1:0]        d_ff, d_in;
   logic [DIV_W-1:0]        rem_ff, rem_in;
   logic [DIV_W-1:0]        dsh_ff, dsh_in;
   logic [DATA_WIDTH-1:0]   q_ff, q_in;
   logic [QCNT_W-1:0]       j_ff, j_in;

   always_comb begin
      state_in = state_ff;
      neg_in   = neg_ff;
      ovf_in   = ovf_ff;
      n_in     = n_ff;
      d_in     = d_ff;
      rem_in   = rem_ff;
      dsh_in   = dsh_ff;
      q_in     = q_ff;
      j_in     = j_ff;
      case (state_ff)
         D_IDLE: begin
            if (start) begin
               neg_in   = cof[COF_W-1] ^ det[DET_W-1];
               n_in     = cof[COF_W-1] ? (~cof + 1'b1) : cof;
               d_in     = det[DET_W-1] ? (~det + 1'b1) : det;
               state_in = D_PREP;
            end
         end
         D_PREP: begin
            // Numerator carries the half divisor so the floor rounds to nearest.
            rem_in   = (DIV_W'(n_ff) << (2 * FRAC_BITS + 1)) + DIV_W'(d_ff);
            dsh_in   = DIV_W'(d_ff) << 1;
            state_in = D_CHK;
         end
         D_CHK: begin
            ovf_in   = (rem_ff >= (dsh_ff << DATA_WIDTH));
            dsh_in   = dsh_ff << (DATA_WIDTH - 1);
            q_in     = '0;
            j_in     = QCNT_W'(DATA_WIDTH - 1);
            state_in = ovf_in ? D_DONE : D_ITER;
         end
         D_ITER: begin
            if (rem_ff >= dsh_ff) begin
               rem_in = rem_ff - dsh_ff;
               q_in   = q_ff | (DATA_WIDTH'(1) << j_ff);
            end
            dsh_in = dsh_ff >> 1;
            j_in   = j_ff - 1'b1;
            if (j_ff == '0) begin
               state_in = D_DONE;
            end
         end
         D_DONE: begin
            state_in = D_IDLE;
         end
         default: begin
            state_in = D_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
      end else begin
         state_ff <= state_in;
      end
      neg_ff <= neg_in;
      ovf_ff <= ovf_in;
      n_ff   <= n_in;
      d_ff   <= d_in;
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      q_ff   <= q_in;
      j_ff   <= j_in;
   end

   assign done = (state_ff == D_DONE);

   always_comb begin
      if (ovf_ff) begin
         quot = neg_ff ? MINV : MAXV;
      end else if (!neg_ff) begin
         quot = q_ff[DATA_WIDTH-1] ? MAXV : q_ff;
      end else if (q_ff[DATA_WIDTH-1] && (q_ff[DATA_WIDTH-2:0] != '0)) begin
         quot = MINV;
      end else begin
         quot = ~q_ff + 1'b1;
      end
   end

endmodule

FILE: rtl/mi4_back.sv
// Back end: sequencer that forms cofactors and determinant, then divides.
module mi4_back import mi4_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  job_type                      job,
   output job_ctl_type                  job_ctl,
   output logic [MAT_AW-1:0]            mat_raddr,
   input  logic [DATA_WIDTH-1:0]        mat_rdata,
   output logic signed [DATA_WIDTH-1:0] rsp_inv_value,
   output logic [IDX_W-1:0]             rsp_position,
   output logic                         rsp_singular,
   output logic                         rsp_last,
   output logic                         empty,
   input  logic                         pop
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_RDA,
      S_RDB,
      S_LDB,
      S_MUL,
      S_DRAIN,
      S_ACC,
      S_COFWR,
      S_DETDONE,
      S_DRD,
      S_DLD,
      S_DIV,
      S_OUT
   } state_type;

   function automatic logic [1:0] skip2(input logic [1:0] x, input logic [1:0] ex);
      skip2 = (x < ex) ? x : x + 2'd1;
   endfunction

   // Element of the 3x3 submatrix that leaves out the row and column of c.
   function automatic logic [IDX_W-1:0] elem_at(input logic [IDX_W-1:0] c,
                                               input logic [1:0] rs,
                                               input logic [1:0] cs);
      elem_at = {skip2(rs, c[3:2]), skip2(cs, c[1:0])};
   endfunction

   state_type                    state_ff, state_in;
   logic                         bank_ff, bank_in;
   logic                         det_phase_ff, det_phase_in;
   logic [IDX_W-1:0]             c_ff, c_in;
   logic [1:0]                   t_ff, t_in;
   logic [1:0]                   h_ff, h_in;
   logic [LIMB_CNT_W-1:0]        k_ff, k_in;
   logic [LIMB_CNT_W-1:0]        top_ff, top_in;
   logic signed [DATA_WIDTH-1:0] opa_ff, opa_in;
   logic [OPB_W-1:0]             opb_ff, opb_in;
   logic signed [PROD_W-1:0]     p_ff, p_in;
   logic                         pv_ff, pv_in;
   logic [DET_W-1:0]             tsum_ff, tsum_in;
   logic [MIN_W-1:0]             minor_ff, minor_in;
   logic [DET_W-1:0]             acc_ff, acc_in;
   logic [DET_W-1:0]             det_ff, det_in;
   logic [DATA_WIDTH-1:0]        res_ff, res_in;
   logic                         out_valid_ff, out_valid_in;
   logic [DATA_WIDTH-1:0]        out_value_ff, out_value_in;
   logic [IDX_W-1:0]             out_pos_ff, out_pos_in;
   logic                         out_sing_ff, out_sing_in;
   logic                         out_last_ff, out_last_in;

   logic [1:0]              col_u, col_v;
   logic [IDX_W-1:0]        addr_a, addr_b;
   logic                    cof_we;
   logic [IDX_W-1:0]        cof_raddr;
   logic [COF_W-1:0]        cof_rdata;
   logic [LIMB_W-1:0]       limb;
   logic signed [LIMB_W:0]  limb_ext;
   logic                    det_zero;
   logic                    div_start;
   logic                    div_done;
   logic [DATA_WIDTH-1:0]   div_quot;
   logic                    term_neg;
   logic                    out_free;

   mi4_ram #(
      .WIDTH (COF_W),
      .DEPTH (NUM_ELEMS)
   ) u_cof_ram (
      .clock   (clock),
      .wr_en   (cof_we),
      .wr_addr (c_ff),
      .wr_data (acc_ff[COF_W-1:0]),
      .rd_addr (cof_raddr),
      .rd_data (cof_rdata)
   );

   mi4_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .cof   (cof_rdata),
      .det   (det_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   // The two columns that remain once the leading column t is taken out.
   assign col_u = (t_ff == 2'd0) ? 2'd1 : 2'd0;
   assign col_v = (t_ff == 2'd2) ? 2'd1 : 2'd2;

   always_comb begin
      if (det_phase_ff) begin
         addr_a = {2'b00, c_ff[1:0]};
      end else begin
         case (h_ff)
            2'd0: addr_a = elem_at(c_ff, 2'd1, col_u);
            2'd1: addr_a = elem_at(c_ff, 2'd1, col_v);
            default: addr_a = elem_at(c_ff, 2'd0, t_ff);
         endcase
      end
      addr_b = (h_ff == 2'd0) ? elem_at(c_ff, 2'd2, col_v) : elem_at(c_ff, 2'd2, col_u);
   end

   assign mat_raddr = {bank_ff, (state_ff == S_RDB) ? addr_b : addr_a};
   // Results leave in row-major order, the adjugate is the transposed cofactors.
   assign cof_raddr = (state_ff == S_DRD) ? {c_ff[1:0], c_ff[3:2]} : c_ff;
   assign cof_we    = (state_ff == S_COFWR);

   assign limb      = opb_ff[k_ff*LIMB_W +: LIMB_W];
   assign limb_ext  = {(k_ff == top_ff) ? limb[LIMB_W-1] : 1'b0, limb};
   assign det_zero  = (det_ff == '0);
   assign div_start = (state_ff == S_DLD) && !det_zero;
   assign term_neg  = (t_ff == 2'd1) ^ c_ff[2] ^ c_ff[0];
   assign out_free  = !out_valid_ff || pop;

   assign job_ctl.pop       = (state_ff == S_IDLE) && job.valid;
   assign job_ctl.free_bank = (state_ff == S_DETDONE);

   always_comb begin
      state_in     = state_ff;
      bank_in      = bank_ff;
      det_phase_in = det_phase_ff;
      c_in         = c_ff;
      t_in         = t_ff;
      h_in         = h_ff;
      k_in         = k_ff;
      top_in       = top_ff;
      opa_in       = opa_ff;
      opb_in       = opb_ff;
      p_in         = opa_ff * limb_ext;
      pv_in        = 1'b0;
      tsum_in      = tsum_ff;
      minor_in     = minor_ff;
      acc_in       = acc_ff;
      det_in       = det_ff;
      res_in       = res_ff;
      out_valid_in = out_valid_ff && !pop;
      out_value_in = out_value_ff;
      out_pos_in   = out_pos_ff;
      out_sing_in  = out_sing_ff;
      out_last_in  = out_last_ff;
      case (state_ff)
         S_IDLE: begin
            if (job.valid) begin
               bank_in      = job.bank;
               det_phase_in = 1'b0;
               c_in         = '0;
               t_in         = 2'd0;
               h_in         = 2'd0;
               acc_in       = '0;
               minor_in     = '0;
               state_in     = S_RDA;
            end
         end
         S_RDA: begin
            state_in = S_RDB;
         end
         S_RDB: begin
            opa_in  = mat_rdata;
            tsum_in = '0;
            if (det_phase_ff) begin
               opb_in   = OPB_W'($signed(cof_rdata));
               top_in   = TOP_C;
               k_in     = TOP_C;
               state_in = S_MUL;
            end else if (h_ff == 2'd2) begin
               opb_in   = OPB_W'($signed(minor_ff));
               top_in   = TOP_M;
               k_in     = TOP_M;
               state_in = S_MUL;
            end else begin
               state_in = S_LDB;
            end
         end
         S_LDB: begin
            opb_in   = OPB_W'($signed(mat_rdata));
            top_in   = TOP_E;
            k_in     = TOP_E;
            state_in = S_MUL;
         end
         S_MUL: begin
            // Limbs go from the top down, so the partial sum shifts up each step.
            pv_in = 1'b1;
            if (pv_ff) begin
               tsum_in = (tsum_ff << LIMB_W) + DET_W'(p_ff);
            end
            k_in = k_ff - 1'b1;
            if (k_ff == '0) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            tsum_in  = (tsum_ff << LIMB_W) + DET_W'(p_ff);
            state_in = S_ACC;
         end
         S_ACC: begin
            state_in = S_RDA;
            if (det_phase_ff) begin
               acc_in = acc_ff + tsum_ff;
               c_in   = c_ff + 1'b1;
               if (c_ff == IDX_W'(3)) begin
                  state_in = S_DETDONE;
               end
            end else begin
               case (h_ff)
                  2'd0: begin
                     minor_in = minor_ff + tsum_ff[MIN_W-1:0];
                     h_in     = 2'd1;
                  end
                  2'd1: begin
                     minor_in = minor_ff - tsum_ff[MIN_W-1:0];
                     h_in     = 2'd2;
                  end
                  default: begin
                     acc_in   = term_neg ? (acc_ff - tsum_ff) : (acc_ff + tsum_ff);
                     minor_in = '0;
                     h_in     = 2'd0;
                     t_in     = t_ff + 2'd1;
                     if (t_ff == 2'd2) begin
                        t_in     = 2'd0;
                        state_in = S_COFWR;
                     end
                  end
               endcase
            end
         end
         S_COFWR: begin
            acc_in   = '0;
            c_in     = c_ff + 1'b1;
            state_in = S_RDA;
            if (c_ff == LAST_IDX) begin
               det_phase_in = 1'b1;
            end
         end
         S_DETDONE: begin
            det_in   = acc_ff;
            c_in     = '0;
            state_in = S_DRD;
         end
         S_DRD: begin
            state_in = S_DLD;
         end
         S_DLD: begin
            if (det_zero) begin
               res_in   = '0;
               state_in = S_OUT;
            end else begin
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (div_done) begin
               res_in   = div_quot;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_value_in = res_ff;
               out_pos_in   = c_ff;
               out_sing_in  = det_zero;
               out_last_in  = (c_ff == LAST_IDX);
               c_in         = c_ff + 1'b1;
               state_in     = (c_ff == LAST_IDX) ? S_IDLE : S_DRD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
         pv_ff        <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         pv_ff        <= pv_in;
      end
      bank_ff      <= bank_in;
      det_phase_ff <= det_phase_in;
      c_ff         <= c_in;
      t_ff         <= t_in;
      h_ff         <= h_in;
      k_ff         <= k_in;
      top_ff       <= top_in;
      opa_ff       <= opa_in;
      opb_ff       <= opb_in;
      p_ff         <= p_in;
      tsum_ff      <= tsum_in;
      minor_ff     <= minor_in;
      acc_ff       <= acc_in;
      det_ff       <= det_in;
      res_ff       <= res_in;
      out_value_ff <= out_value_in;
      out_pos_ff   <= out_pos_in;
      out_sing_ff  <= out_sing_in;
      out_last_ff  <= out_last_in;
   end

   assign empty         = !out_valid_ff;
   assign rsp_inv_value = out_value_ff;
   assign rsp_position  = out_pos_ff;
   assign rsp_singular  = out_sing_ff;
   assign rsp_last      = out_last_ff;

endmodule

FILE: rtl/matrix4_inverse.sv
// Top level of the 4x4 fixed-point matrix inverse: front end, store and back end.
// A request is taken whenever full is low; after the sixteenth, the back end forms the
// 16 cofactors on the shared limb multiplier, then the determinant, and then does one
// divide per result on the divider; the next matrix loads meanwhile.
// Reset clears the counters, the queue and the result valid flag; the store is not cleared.
module matrix4_inverse import mi4_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   output logic                         full,
   input  logic signed [DATA_WIDTH-1:0] req_element,
   output logic signed [DATA_WIDTH-1:0] rsp_inv_value,
   output logic [IDX_W-1:0]             rsp_position,
   output logic                         rsp_singular,
   output logic                         rsp_last,
   output logic                         empty,
   input  logic                         pop
);

   // The matrix store has two banks, so the front end can take the next
   // matrix while the back end still works on the previous one. The front
   // end raises full only when both banks hold matrices not yet consumed.
   logic                  mat_we;
   logic [MAT_AW-1:0]     mat_waddr;
   logic [DATA_WIDTH-1:0] mat_wdata;
   logic [MAT_AW-1:0]     mat_raddr;
   logic [DATA_WIDTH-1:0] mat_rdata;
   job_type               job;
   job_ctl_type           job_ctl;

   // The front end writes each request into the store and, on the sixteenth,
   // posts the bank to a two-entry queue for the back end.
   mi4_front u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .full        (full),
      .req_element (req_element),
      .mat_we      (mat_we),
      .mat_waddr   (mat_waddr),
      .mat_wdata   (mat_wdata),
      .job         (job),
      .job_ctl     (job_ctl)
   );

   mi4_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (MAT_DEPTH)
   ) u_mat_ram (
      .clock   (clock),
      .wr_en   (mat_we),
      .wr_addr (mat_waddr),
      .wr_data (mat_wdata),
      .rd_addr (mat_raddr),
      .rd_data (mat_rdata)
   );

   // The back end computes exact cofactors and the determinant with one
   // signed multiplier that walks the wide operand in 16-bit limbs, frees
   // the bank once the determinant is known, and then divides each adjugate
   // element by it, or gives zero when it is zero, into the registers that drive the outputs.
   mi4_back u_back (
      .clock         (clock),
      .reset         (reset),
      .job           (job),
      .job_ctl       (job_ctl),
      .mat_raddr     (mat_raddr),
      .mat_rdata     (mat_rdata),
      .rsp_inv_value (rsp_inv_value),
      .rsp_position  (rsp_position),
      .rsp_singular  (rsp_singular),
      .rsp_last      (rsp_last),
      .empty         (empty),
      .pop           (pop)
   );

   // The last flag marks exactly the final element of the matrix.
   a_last_pos: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_last == (rsp_position == LAST_IDX)))
      else $error("last flag does not match the final position");

   // A singular matrix yields zero values.
   a_sing_zero: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_singular) |-> (rsp_inv_value == '0))
      else $error("nonzero value on a singular result");

   // The back end only takes a matrix that the queue holds.
   a_job_pop: assert property (@(posedge clock) disable iff (reset)
      job_ctl.pop |-> job.valid)
      else $error("job taken from an empty queue");

endmodule
